### sv/dmca_pkg.sv
`default_nettype none

package dmca_pkg;

	localparam int MEM_WORDS   = 1024;
	localparam int CACHE_WORDS = 64;
	localparam int BLOCK_WORDS = 4;
	localparam int NUM_LINES   = ((CACHE_WORDS / BLOCK_WORDS) > 0) ?
		(CACHE_WORDS / BLOCK_WORDS) : 1;
	localparam int DATA_WORDS  = NUM_LINES * BLOCK_WORDS;

	localparam int ADDR_W = $clog2(MEM_WORDS);
	localparam int OFF_W  = $clog2(BLOCK_WORDS);
	localparam int LINE_W = $clog2(NUM_LINES);
	localparam int TAG_W  = ADDR_W - OFF_W - LINE_W;
	localparam int SLOT_W = $clog2(DATA_WORDS);
	localparam int FCNT_W = $clog2(BLOCK_WORDS + 1);
	localparam int WORD_W = 32;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic               op;
		logic [9:0]         address;
		logic signed [31:0] write_value;
	} dmca_in_t;

	typedef struct packed {
		logic               hit;
		logic [1:0]         word_offset;
		logic [3:0]         line_index;
		logic [3:0]         tag_value;
		logic signed [31:0] data_value;
	} dmca_out_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOOKUP,
		ST_FILL,
		ST_ACCESS,
		ST_RESP
	} dmca_state_t;

	typedef struct packed {
		logic init_step;
		logic capture_in;
		logic lookup;
		logic fill_clear;
		logic fill_step;
		logic fill_done;
		logic access;
		logic load_out;
	} dmca_cmd_t;

	typedef struct packed {
		logic init_last;
		logic hit;
		logic fill_last;
	} dmca_status_t;

endpackage

`default_nettype wire

### sv/dmca_ctrl.sv
`default_nettype none

module dmca_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire dmca_pkg::dmca_status_t status,
	output dmca_pkg::dmca_cmd_t        cmd
);

	dmca_pkg::dmca_state_t state_q;
	dmca_pkg::dmca_state_t state_d;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmca_pkg::ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			dmca_pkg::ST_INIT: begin
				cmd.init_step = 1'b1;
				if (status.init_last) begin
					state_d = dmca_pkg::ST_IDLE;
				end
			end
			dmca_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture_in = 1'b1;
					state_d        = dmca_pkg::ST_LOOKUP;
				end
			end
			dmca_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (status.hit) begin
					state_d = dmca_pkg::ST_ACCESS;
				end else begin
					cmd.fill_clear = 1'b1;
					state_d        = dmca_pkg::ST_FILL;
				end
			end
			dmca_pkg::ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (status.fill_last) begin
					cmd.fill_done = 1'b1;
					state_d       = dmca_pkg::ST_ACCESS;
				end
			end
			dmca_pkg::ST_ACCESS: begin
				cmd.access = 1'b1;
				state_d    = dmca_pkg::ST_RESP;
			end
			dmca_pkg::ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = dmca_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dmca_pkg::ST_INIT;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### sv/dmca_dp.sv
`default_nettype none

module dmca_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dmca_pkg::dmca_in_t  in_data,
	input  wire dmca_pkg::dmca_cmd_t cmd,
	output dmca_pkg::dmca_status_t   status,
	output dmca_pkg::dmca_out_t      out_data
);

	dmca_pkg::dmca_in_t  in_q;
	dmca_pkg::dmca_out_t out_q;
	logic                hit_q;

	logic [dmca_pkg::WORD_W-1:0] main_mem_q [dmca_pkg::MEM_WORDS];
	logic [dmca_pkg::WORD_W-1:0] cache_mem_q [dmca_pkg::DATA_WORDS];
	logic [dmca_pkg::TAG_W-1:0]  tags_q [dmca_pkg::NUM_LINES];
	logic [dmca_pkg::NUM_LINES-1:0] valid_q;

	logic [dmca_pkg::WORD_W-1:0] mem_rd_q;
	logic [dmca_pkg::WORD_W-1:0] cache_rd_q;
	logic [dmca_pkg::FCNT_W-1:0] fill_cnt_q;
	logic [dmca_pkg::ADDR_W-1:0] init_cnt_q;

	logic [dmca_pkg::ADDR_W-1:0] addr;
	logic [dmca_pkg::OFF_W-1:0]  offset;
	logic [dmca_pkg::LINE_W-1:0] line;
	logic [dmca_pkg::TAG_W-1:0]  tag;
	logic [dmca_pkg::SLOT_W-1:0] slot;
	logic [dmca_pkg::ADDR_W-1:0] fill_addr;
	logic [dmca_pkg::FCNT_W-1:0] fill_prev;
	logic [dmca_pkg::SLOT_W-1:0] fill_slot;
	logic                        is_write;

	logic                        mem_we;
	logic [dmca_pkg::ADDR_W-1:0] mem_wa;
	logic [dmca_pkg::WORD_W-1:0] mem_wd;
	logic                        cache_we;
	logic [dmca_pkg::SLOT_W-1:0] cache_wa;
	logic [dmca_pkg::WORD_W-1:0] cache_wd;

	assign addr     = in_q.address[dmca_pkg::ADDR_W-1:0];
	assign offset   = addr[dmca_pkg::OFF_W-1:0];
	assign line     = addr[dmca_pkg::OFF_W+dmca_pkg::LINE_W-1:dmca_pkg::OFF_W];
	assign tag      = addr[dmca_pkg::ADDR_W-1:dmca_pkg::OFF_W+dmca_pkg::LINE_W];
	assign slot     = {line, offset};
	assign is_write = (in_q.op == dmca_pkg::OP_WRITE);

	// The block base is aligned, so the fill address only replaces the offset bits.
	assign fill_addr = {addr[dmca_pkg::ADDR_W-1:dmca_pkg::OFF_W],
		fill_cnt_q[dmca_pkg::OFF_W-1:0]};
	assign fill_prev = fill_cnt_q - dmca_pkg::FCNT_W'(1);
	assign fill_slot = {line, fill_prev[dmca_pkg::OFF_W-1:0]};

	always_comb begin
		mem_we = cmd.init_step || (cmd.access && is_write);
		if (cmd.init_step) begin
			mem_wa = init_cnt_q;
			mem_wd = dmca_pkg::WORD_W'(dmca_pkg::MEM_WORDS) -
				dmca_pkg::WORD_W'(init_cnt_q);
		end else begin
			mem_wa = addr;
			mem_wd = in_q.write_value;
		end
	end

	always_comb begin
		cache_we = (cmd.fill_step && (fill_cnt_q != '0)) || (cmd.access && is_write);
		if (cmd.fill_step) begin
			cache_wa = fill_slot;
			cache_wd = mem_rd_q;
		end else begin
			cache_wa = slot;
			cache_wd = in_q.write_value;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			main_mem_q[mem_wa] <= mem_wd;
		end
		if (cmd.fill_step) begin
			mem_rd_q <= main_mem_q[fill_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cache_we) begin
			cache_mem_q[cache_wa] <= cache_wd;
		end
		if (cmd.access && !is_write) begin
			cache_rd_q <= cache_mem_q[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_done) begin
			tags_q[line] <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			init_cnt_q <= '0;
			fill_cnt_q <= '0;
		end else begin
			if (cmd.fill_done) begin
				valid_q[line] <= 1'b1;
			end
			if (cmd.init_step) begin
				init_cnt_q <= init_cnt_q + dmca_pkg::ADDR_W'(1);
			end
			if (cmd.fill_clear) begin
				fill_cnt_q <= '0;
			end else if (cmd.fill_step) begin
				fill_cnt_q <= fill_cnt_q + dmca_pkg::FCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_in) begin
			in_q <= in_data;
		end
		if (cmd.lookup) begin
			hit_q <= status.hit;
		end
		if (cmd.load_out) begin
			out_q.hit         <= hit_q;
			out_q.word_offset <= 2'(offset);
			out_q.line_index  <= 4'(line);
			out_q.tag_value   <= 4'(tag);
			out_q.data_value  <= is_write ? in_q.write_value : $signed(cache_rd_q);
		end
	end

	assign status.hit       = valid_q[line] && (tags_q[line] == tag);
	assign status.fill_last = (fill_cnt_q == dmca_pkg::FCNT_W'(dmca_pkg::BLOCK_WORDS));
	assign status.init_last = (init_cnt_q == dmca_pkg::ADDR_W'(dmca_pkg::MEM_WORDS - 1));
	assign out_data         = out_q;

endmodule

`default_nettype wire

### sv/direct_mapped_cache_access_top.sv
// Channel   Signals                          Payload type
// in        in_valid, in_ready, in_data      dmca_pkg::dmca_in_t
// out       out_valid, out_ready, out_data   dmca_pkg::dmca_out_t
//
// A hit passes from acceptance to the result register through lookup, access and response;
// the response waits while an untaken result is held, and the next transaction is accepted in idle.
// A miss adds the fill state, one main memory read per block word plus one step for the
// registered read data, which is then written into the cache line.
// After reset the main memory is preset one word per cycle, all MEM_WORDS (1024) words,
// and no transaction is accepted until that sweep ends.
// A new transaction is accepted while a result still waits in the output register.
`default_nettype none

module direct_mapped_cache_access_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire dmca_pkg::dmca_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output dmca_pkg::dmca_out_t      out_data
);

	dmca_pkg::dmca_cmd_t    cmd;
	dmca_pkg::dmca_status_t status;

	dmca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dmca_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

	a_fill_then_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_done |=> status.hit)
		else $error("Line does not hit after its fill.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("Result register loaded while holding an untaken result.");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.init_step, cmd.capture_in, cmd.lookup, cmd.fill_step,
			cmd.access, cmd.load_out}))
		else $error("More than one controller phase active.");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill_step || cmd.access || cmd.init_step) |-> !in_ready)
		else $error("Input ready while a transaction is in progress.");

endmodule

`default_nettype wire
